// File: rtl/core/lli_pkg.sv
// ============================================================================
// lli_pkg
// Shared widths and types for the two-line intersection pipeline.
// ============================================================================
`default_nettype none

package lli_pkg;

    // coordinate and intermediate widths
    localparam int CW = 32;            // coordinate
    localparam int DW = CW + 1;        // coordinate difference
    localparam int PW = 2 * DW;        // product of two differences
    localparam int EW = PW + 1;        // den / num
    localparam int LS = EW / 2;        // low split of den / num (unsigned part)
    localparam int HW = EW - LS;       // high split (signed part)
    localparam int NW = CW + EW + 2;   // numerators nx / ny
    localparam int QW = CW;            // quotient magnitude bits
    localparam int RW = EW;            // remainder / divisor magnitude

    // one coordinate's state inside the divider
    typedef struct packed {
        logic [RW-1:0] rem;   // partial remainder
        logic [QW-1:0] sq;    // dividend bits left (high) / quotient bits (low)
    } t_div_lane;

endpackage

`default_nettype wire

// File: rtl/core/lli_div_step.sv
// ============================================================================
// lli_div_step
// One registered restoring-division step: one quotient bit per stage.
// ============================================================================
`default_nettype none

module lli_div_step (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire lli_pkg::t_div_lane     i_lane,
    input  wire logic [lli_pkg::RW-1:0] i_dmag,
    output lli_pkg::t_div_lane          o_lane
);

    logic [lli_pkg::RW:0] trial;
    logic [lli_pkg::RW:0] diff;
    lli_pkg::t_div_lane   n_lane;
    lli_pkg::t_div_lane   r_lane;

    // shift in next dividend bit, trial subtract
    always_comb begin
        trial = {i_lane.rem, i_lane.sq[lli_pkg::QW-1]};
        diff  = trial - {1'b0, i_dmag};
        n_lane.rem = diff[lli_pkg::RW] ? trial[lli_pkg::RW-1:0] : diff[lli_pkg::RW-1:0];
        n_lane.sq  = {i_lane.sq[lli_pkg::QW-2:0], ~diff[lli_pkg::RW]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

`default_nettype wire

// File: rtl/core/line_line_intersection.sv
// ============================================================================
// line_line_intersection
// Crossing point of two infinite lines, signed Q16.16, fully pipelined.
// ============================================================================
// Usage:
//   Input channel: eight coordinates (two points per line) with i_valid;
//   the block raises o_stall when it cannot take a transfer.
//   Output channel: o_hit, o_cross_x, o_cross_y, o_clipped with o_valid;
//   the receiver holds i_stall to pause it.
//   Pipeline: 8 arithmetic stages, 32 divider stages, one saturate/output
//   stage, all registered. Throughput: one item per cycle while i_stall
//   does not hold a waiting result; the 32-stage restoring divider makes
//   one quotient bit per stage, two lanes (x and y) side by side.
//   Stall: the whole pipeline freezes while a result waits at the output
//   under i_stall; nothing is lost or repeated. Empty slots do not block.
//   Reset: clears all valid bits; the datapath needs no reset.
//   No hit (parallel or zero-length line): hit, coordinates and clipped
//   are all zero. Out-of-range points saturate and set clipped.
// ============================================================================
`default_nettype none

module line_line_intersection (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic signed [lli_pkg::CW-1:0]   i_a_start_x,
    input  wire logic signed [lli_pkg::CW-1:0]   i_a_start_y,
    input  wire logic signed [lli_pkg::CW-1:0]   i_a_end_x,
    input  wire logic signed [lli_pkg::CW-1:0]   i_a_end_y,
    input  wire logic signed [lli_pkg::CW-1:0]   i_b_start_x,
    input  wire logic signed [lli_pkg::CW-1:0]   i_b_start_y,
    input  wire logic signed [lli_pkg::CW-1:0]   i_b_end_x,
    input  wire logic signed [lli_pkg::CW-1:0]   i_b_end_y,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic                                 o_hit,
    output logic signed [lli_pkg::CW-1:0]        o_cross_x,
    output logic signed [lli_pkg::CW-1:0]        o_cross_y,
    output logic                                 o_clipped
);

    localparam int CW = lli_pkg::CW;
    localparam int DW = lli_pkg::DW;
    localparam int PW = lli_pkg::PW;
    localparam int EW = lli_pkg::EW;
    localparam int LS = lli_pkg::LS;
    localparam int HW = lli_pkg::HW;
    localparam int NW = lli_pkg::NW;
    localparam int QW = lli_pkg::QW;
    localparam int RW = lli_pkg::RW;

    logic en;

    // global advance: move unless a result waits under stall
    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    // ---------------- stage 1: differences ----------------
    logic                 r_v1;
    logic signed [CW-1:0] r_ax1, r_ay1;
    logic signed [DW-1:0] r_d1x1, r_d1y1, r_d2x1, r_d2y1, r_ex1, r_ey1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax1  <= i_a_start_x;
            r_ay1  <= i_a_start_y;
            r_d1x1 <= DW'(i_a_end_x) - DW'(i_a_start_x);
            r_d1y1 <= DW'(i_a_end_y) - DW'(i_a_start_y);
            r_d2x1 <= DW'(i_b_end_x) - DW'(i_b_start_x);
            r_d2y1 <= DW'(i_b_end_y) - DW'(i_b_start_y);
            r_ex1  <= DW'(i_b_start_x) - DW'(i_a_start_x);
            r_ey1  <= DW'(i_b_start_y) - DW'(i_a_start_y);
        end
    end

    // ---------------- stage 2: cross-product terms ----------------
    logic                 r_v2;
    logic signed [CW-1:0] r_ax2, r_ay2;
    logic signed [DW-1:0] r_d1x2, r_d1y2;
    logic signed [PW-1:0] r_p1, r_p2, r_p3, r_p4;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax2  <= r_ax1;
            r_ay2  <= r_ay1;
            r_d1x2 <= r_d1x1;
            r_d1y2 <= r_d1y1;
            r_p1   <= r_d1x1 * r_d2y1;
            r_p2   <= r_d1y1 * r_d2x1;
            r_p3   <= r_ex1 * r_d2y1;
            r_p4   <= r_ey1 * r_d2x1;
        end
    end

    // ---------------- stage 3: den and num ----------------
    logic                 r_v3;
    logic signed [CW-1:0] r_ax3, r_ay3;
    logic signed [DW-1:0] r_d1x3, r_d1y3;
    logic signed [EW-1:0] r_den3, r_num3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax3  <= r_ax2;
            r_ay3  <= r_ay2;
            r_d1x3 <= r_d1x2;
            r_d1y3 <= r_d1y2;
            r_den3 <= EW'(r_p1) - EW'(r_p2);
            r_num3 <= EW'(r_p3) - EW'(r_p4);
        end
    end

    // ---------------- stage 4: split partial products ----------------
    logic                 r_v4;
    logic                 r_hit4;
    logic signed [EW-1:0] r_den4;
    logic signed [CW+HW-1:0]   r_axh, r_ayh;
    logic signed [CW+LS:0]     r_axl, r_ayl;
    logic signed [DW+HW-1:0]   r_dxh, r_dyh;
    logic signed [DW+LS:0]     r_dxl, r_dyl;
    logic signed [HW-1:0] den_hi, num_hi;
    logic signed [LS:0]   den_lo, num_lo;

    assign den_hi = r_den3[EW-1:LS];
    assign num_hi = r_num3[EW-1:LS];
    assign den_lo = {1'b0, r_den3[LS-1:0]};
    assign num_lo = {1'b0, r_num3[LS-1:0]};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit4 <= (r_den3 != '0);
            r_den4 <= r_den3;
            r_axh  <= r_ax3 * den_hi;
            r_axl  <= r_ax3 * den_lo;
            r_ayh  <= r_ay3 * den_hi;
            r_ayl  <= r_ay3 * den_lo;
            r_dxh  <= r_d1x3 * num_hi;
            r_dxl  <= r_d1x3 * num_lo;
            r_dyh  <= r_d1y3 * num_hi;
            r_dyl  <= r_d1y3 * num_lo;
        end
    end

    // ---------------- stage 5: recombine split products ----------------
    logic                 r_v5;
    logic                 r_hit5;
    logic signed [EW-1:0] r_den5;
    logic signed [NW-1:0] r_tax, r_tay, r_tdx, r_tdy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit5 <= r_hit4;
            r_den5 <= r_den4;
            r_tax  <= (NW'(r_axh) <<< LS) + NW'(r_axl);
            r_tay  <= (NW'(r_ayh) <<< LS) + NW'(r_ayl);
            r_tdx  <= (NW'(r_dxh) <<< LS) + NW'(r_dxl);
            r_tdy  <= (NW'(r_dyh) <<< LS) + NW'(r_dyl);
        end
    end

    // ---------------- stage 6: numerators ----------------
    logic                 r_v6;
    logic                 r_hit6;
    logic signed [EW-1:0] r_den6;
    logic signed [NW-1:0] r_nx6, r_ny6;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit6 <= r_hit5;
            r_den6 <= r_den5;
            r_nx6  <= r_tax + r_tdx;
            r_ny6  <= r_tay + r_tdy;
        end
    end

    // ---------------- stage 7: magnitudes and signs ----------------
    logic                 r_v7;
    logic                 r_hit7, r_negx7, r_negy7;
    logic [RW-1:0]        r_dmag7;
    logic [NW-1:0]        r_nxm7, r_nym7;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit7  <= r_hit6;
            r_negx7 <= r_nx6[NW-1] ^ r_den6[EW-1];
            r_negy7 <= r_ny6[NW-1] ^ r_den6[EW-1];
            r_dmag7 <= r_den6[EW-1] ? RW'(-r_den6) : RW'(r_den6);
            r_nxm7  <= r_nx6[NW-1] ? NW'(-r_nx6) : NW'(r_nx6);
            r_nym7  <= r_ny6[NW-1] ? NW'(-r_ny6) : NW'(r_ny6);
        end
    end

    // ---------------- stage 8: quotient range check ----------------
    logic                 r_v8;
    logic                 r_hit8, r_negx8, r_negy8, r_ovx8, r_ovy8;
    logic [RW-1:0]        r_dmag8;
    lli_pkg::t_div_lane   r_lx8, r_ly8;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit8    <= r_hit7;
            r_negx8   <= r_negx7;
            r_negy8   <= r_negy7;
            r_dmag8   <= r_dmag7;
            r_ovx8    <= r_nxm7[NW-1:QW] >= (NW-QW)'(r_dmag7);
            r_ovy8    <= r_nym7[NW-1:QW] >= (NW-QW)'(r_dmag7);
            r_lx8.rem <= r_nxm7[QW+RW-1:QW];
            r_lx8.sq  <= r_nxm7[QW-1:0];
            r_ly8.rem <= r_nym7[QW+RW-1:QW];
            r_ly8.sq  <= r_nym7[QW-1:0];
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    lli_pkg::t_div_lane w_lx [0:QW];
    lli_pkg::t_div_lane w_ly [0:QW];
    logic               r_dv   [0:QW-1];
    logic               r_dhit [0:QW-1];
    logic               r_dngx [0:QW-1];
    logic               r_dngy [0:QW-1];
    logic               r_dovx [0:QW-1];
    logic               r_dovy [0:QW-1];
    logic [RW-1:0]      r_ddm  [0:QW-2];
    logic [RW-1:0]      w_dm   [0:QW-1];

    assign w_lx[0] = r_lx8;
    assign w_ly[0] = r_ly8;

    genvar g;
    generate
        for (g = 0; g < QW; g++) begin : g_div
            assign w_dm[g] = (g == 0) ? r_dmag8 : r_ddm[(g == 0) ? 0 : g - 1];

            lli_div_step u_step_x (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_lane (w_lx[g]),
                .i_dmag (w_dm[g]),
                .o_lane (w_lx[g+1])
            );

            lli_div_step u_step_y (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_lane (w_ly[g]),
                .i_dmag (w_dm[g]),
                .o_lane (w_ly[g+1])
            );
        end
    endgenerate

    // side flags travel alongside the divider lanes
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dhit[0] <= r_hit8;
            r_dngx[0] <= r_negx8;
            r_dngy[0] <= r_negy8;
            r_dovx[0] <= r_ovx8;
            r_dovy[0] <= r_ovy8;
            r_ddm[0]  <= r_dmag8;
            for (int k = 1; k < QW; k++) begin
                r_dhit[k] <= r_dhit[k-1];
                r_dngx[k] <= r_dngx[k-1];
                r_dngy[k] <= r_dngy[k-1];
                r_dovx[k] <= r_dovx[k-1];
                r_dovy[k] <= r_dovy[k-1];
            end
            // divisor is only needed up to the last divider step
            for (int k = 1; k < QW - 1; k++) begin
                r_ddm[k] <= r_ddm[k-1];
            end
        end
    end

    // ---------------- output: sign, saturate, no-hit ----------------
    logic [QW-1:0]        qx, qy;
    logic                 clx, cly;
    logic signed [CW-1:0] n_cx, n_cy;

    assign qx = w_lx[QW].sq;
    assign qy = w_ly[QW].sq;

    always_comb begin
        if (r_dngx[QW-1]) begin
            clx  = r_dovx[QW-1] || (qx[QW-1] && (qx[QW-2:0] != '0));
            n_cx = clx ? {1'b1, {(CW-1){1'b0}}} : -$signed(qx);
        end else begin
            clx  = r_dovx[QW-1] || qx[QW-1];
            n_cx = clx ? {1'b0, {(CW-1){1'b1}}} : $signed(qx);
        end
        if (r_dngy[QW-1]) begin
            cly  = r_dovy[QW-1] || (qy[QW-1] && (qy[QW-2:0] != '0));
            n_cy = cly ? {1'b1, {(CW-1){1'b0}}} : -$signed(qy);
        end else begin
            cly  = r_dovy[QW-1] || qy[QW-1];
            n_cy = cly ? {1'b0, {(CW-1){1'b1}}} : $signed(qy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_hit     <= r_dhit[QW-1];
            o_cross_x <= r_dhit[QW-1] ? n_cx : '0;
            o_cross_y <= r_dhit[QW-1] ? n_cy : '0;
            o_clipped <= r_dhit[QW-1] && (clx || cly);
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
            for (int k = 0; k < QW; k++) begin
                r_dv[k] <= 1'b0;
            end
            o_valid <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
            r_dv[0] <= r_v8;
            for (int k = 1; k < QW; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            o_valid <= r_dv[QW-1];
        end
    end

endmodule

`default_nettype wire

// File: tb/tb_line_line_intersection.sv
// ============================================================================
// tb_line_line_intersection
// Self-checking bench for the two-line intersection pipeline: directed
// corner cases, then random line pairs, checked against an exact
// wide-integer model of the crossing point with truncation and saturation.
// ============================================================================
`default_nettype none

module tb_line_line_intersection;

    typedef struct {
        logic                hit;
        logic signed [31:0]  cx;
        logic signed [31:0]  cy;
        logic                clipped;
    } t_crossing;

    localparam int LATENCY   = 41;
    localparam int MAX_CYCLE = 400000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_a_start_x, i_a_start_y, i_a_end_x, i_a_end_y;
    logic signed [31:0] i_b_start_x, i_b_start_y, i_b_end_x, i_b_end_y;
    logic               o_valid;
    logic               i_stall;
    logic               o_hit;
    logic signed [31:0] o_cross_x, o_cross_y;
    logic               o_clipped;

    t_crossing expected_q[$];
    int        n_errors;
    int        cycle;
    bit        quiet_tail;
    bit        hold_rx;
    int        hold_len;

    line_line_intersection DUT (.*);

    // clock
    always begin
        i_clk = 1'b0; #2;
        i_clk = 1'b1; #2;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // round quotient toward zero, then clamp to 32 bits
    function automatic logic signed [31:0] clamp_coord(input logic signed [191:0] n,
                                                       input logic signed [191:0] d,
                                                       inout logic clip);
        logic signed [191:0] q;
        q = n / d;
        if (q > 192'sd2147483647) begin
            clip = 1'b1;
            return 32'sh7fffffff;
        end
        if (q < -192'sd2147483648) begin
            clip = 1'b1;
            return 32'sh80000000;
        end
        return q[31:0];
    endfunction

    function automatic t_crossing predict_crossing(input logic signed [31:0] p[8]);
        logic signed [191:0] ax, ay, d1x, d1y, bx, by, d2x, d2y, den, num, nx, ny;
        t_crossing r;
        logic clip;
        ax  = p[0];         ay  = p[1];
        d1x = p[2] - ax;    d1y = p[3] - ay;
        bx  = p[4];         by  = p[5];
        d2x = p[6] - bx;    d2y = p[7] - by;
        den = d1x * d2y - d1y * d2x;
        r = '{1'b0, 32'sd0, 32'sd0, 1'b0};
        if (den == 0) return r;
        num = (bx - ax) * d2y - (by - ay) * d2x;
        nx  = ax * den + d1x * num;
        ny  = ay * den + d1y * num;
        clip = 1'b0;
        r.hit = 1'b1;
        r.cx  = clamp_coord(nx, den, clip);
        r.cy  = clamp_coord(ny, den, clip);
        r.clipped = clip;
        return r;
    endfunction

    // receiver stall: random bursts, or a long hold on request
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                i_stall <= 1'b1;
                repeat (hold_len) @(negedge i_clk);
                hold_rx = 1'b0;
                i_stall <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_crossing e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                $error("result with nothing expected");
                n_errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_hit !== e.hit) begin
                    $error("hit: expected %0d actual %0d", e.hit, o_hit); n_errors++;
                end
                if (o_cross_x !== e.cx) begin
                    $error("cross_x: expected %0d actual %0d", e.cx, o_cross_x);
                    n_errors++;
                end
                if (o_cross_y !== e.cy) begin
                    $error("cross_y: expected %0d actual %0d", e.cy, o_cross_y);
                    n_errors++;
                end
                if (o_clipped !== e.clipped) begin
                    $error("clipped: expected %0d actual %0d", e.clipped, o_clipped);
                    n_errors++;
                end
            end
        end
    end

    // one input transfer, with optional random gap first
    task automatic send_lines(input logic signed [31:0] p[8]);
        if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        {i_a_start_x, i_a_start_y, i_a_end_x, i_a_end_y} <= {p[0], p[1], p[2], p[3]};
        {i_b_start_x, i_b_start_y, i_b_end_x, i_b_end_y} <= {p[4], p[5], p[6], p[7]};
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        expected_q.push_back(predict_crossing(p));
        @(negedge i_clk);
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0:       return $urandom();
            1:       return $signed($urandom_range(0, 2000)) - 1000;
            2:       return ($signed($urandom_range(0, 200)) - 100) <<< 16;
            3:       return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 3)
                                                 : 32'sh80000000 + $urandom_range(0, 3);
            default: return ($signed($urandom_range(0, 65535)) - 32768) <<< 12;
        endcase
    endfunction

    task automatic test_directed();
        logic signed [31:0] p[8];
        localparam logic signed [31:0] ONE = 32'sh10000;
        localparam logic signed [31:0] MX = 32'sh7fffffff, MN = 32'sh80000000;
        // plain crossing of the axes
        p = '{-ONE, 0, ONE, 0, 0, -ONE, 0, ONE};          send_lines(p);
        // parallel lines
        p = '{0, 0, ONE, ONE, 0, ONE, ONE, 2*ONE};         send_lines(p);
        // coincident lines
        p = '{0, 0, ONE, ONE, 2*ONE, 2*ONE, 3*ONE, 3*ONE}; send_lines(p);
        // zero-length first, then second line
        p = '{ONE, ONE, ONE, ONE, 0, 0, ONE, 0};           send_lines(p);
        p = '{0, 0, ONE, 0, ONE, ONE, ONE, ONE};           send_lines(p);
        // vertical first line, vertical second line
        p = '{3*ONE+5, 0, 3*ONE+5, ONE, 0, 7, ONE, 2*ONE}; send_lines(p);
        p = '{0, 0, ONE, 3, -ONE+1, 0, -ONE+1, ONE};       send_lines(p);
        // truncation toward zero, negative side
        p = '{0, 0, 3, 1, -1, -1, -1, 5};                  send_lines(p);
        // range edges: nearly parallel lines crossing at the coordinate limits
        p = '{0, 0, MX, 1, 0, 1, MX, 1};                   send_lines(p);
        p = '{0, 0, MN, 1, 0, 1, MN, 1};                   send_lines(p);
        p = '{0, 0, 1, MX, 1, 0, 1, MN};                   send_lines(p);
        // extreme values in the fields
        p = '{MN, MN, MX, MX, MN, MX, MX, MN};             send_lines(p);
        p = '{MX, MN, MN, MX, MX, MX, MN, MN};             send_lines(p);
        p = '{-1, -1, MX, 0, MN, -1, 0, MX};               send_lines(p);
        go_idle();
    endtask

    task automatic test_random(input int count);
        logic signed [31:0] p[8];
        for (int k = 0; k < count; k++) begin
            foreach (p[j]) p[j] = rand_coord();
            // sometimes force a parallel pair, a zero-length or a vertical first line
            case ($urandom_range(0, 9))
                0: begin p[6] = p[4] + (p[2] - p[0]); p[7] = p[5] + (p[3] - p[1]); end
                1: begin p[2] = p[0]; p[3] = p[1]; end
                2: p[2] = p[0];
                default: ;
            endcase
            send_lines(p);
        end
        go_idle();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        hold_len = 300;
        @(negedge i_clk);
        hold_rx = 1'b1;
        test_random(80);
    endtask

    task automatic wait_drained();
        go_idle();
        while (expected_q.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        n_errors = 0; cycle = 0; quiet_tail = 0; hold_rx = 0; hold_len = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        {i_a_start_x, i_a_start_y, i_a_end_x, i_a_end_y} = '0;
        {i_b_start_x, i_b_start_y, i_b_end_x, i_b_end_y} = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_backpressure();
        wait_drained();        // sender pauses until all results are back
        test_random(450);
        quiet_tail = 1;
        test_random(150);
        wait_drained();
        repeat (LATENCY + 10) @(negedge i_clk);

        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/lli_pkg.sv
rtl/core/lli_div_step.sv
rtl/core/line_line_intersection.sv
tb/tb_line_line_intersection.sv
